// ----- hdl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // Pattern storage is fixed at two 64-bit registers
   localparam int PATTERN_BYTES = 16;
   localparam int LEN_W         = 6;   // effective length width; len_eff is clamped to MAX_PATTERN_BYTES
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;

   // Register indexes (paddr[5:3])
   localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [2:0] REG_CARE_MASK    = 3'd2;
   localparam logic [2:0] REG_PATTERN_LEN  = 3'd3;
   localparam logic [2:0] REG_RESULT_OFF   = 3'd4;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] care_mask;
      logic [4:0]  pattern_length;
      logic [15:0] result_offset;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic        region_start;
      logic        scan_start;
      logic        scan_end;
   } item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_address;
   } result_type;

   // Pattern byte at position pos; positions 16 and up read as zero
   function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                               input logic [63:0] hi,
                                               input int pos);
      logic [7:0] b;
      b = 8'h00;
      if (pos < 8) begin
         b = lo[8*pos +: 8];
      end else if (pos < PATTERN_BYTES) begin
         b = hi[8*(pos-8) +: 8];
      end
      return b;
   endfunction

endpackage

// ----- hdl/mbps_regs.sv -----
// ----------------------------------------------------------------------------
// mbps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mbps_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output mbps_pkg::cfg_type             cfg
);
   import mbps_pkg::*;

   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [15:0] care_mask_ff;
   logic [4:0]  pattern_length_ff;
   logic [15:0] result_offset_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign wr_en   = psel & penable & pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= 5'd1;
         result_offset_ff  <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PATTERN_LOW:  pattern_low_ff    <= pwdata;
            REG_PATTERN_HIGH: pattern_high_ff   <= pwdata;
            REG_CARE_MASK:    care_mask_ff      <= pwdata[15:0];
            REG_PATTERN_LEN:  pattern_length_ff <= pwdata[4:0];
            REG_RESULT_OFF:   result_offset_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_PATTERN_LOW:  prdata = pattern_low_ff;
         REG_PATTERN_HIGH: prdata = pattern_high_ff;
         REG_CARE_MASK:    prdata = {48'h0, care_mask_ff};
         REG_PATTERN_LEN:  prdata = {59'h0, pattern_length_ff};
         REG_RESULT_OFF:   prdata = {48'h0, result_offset_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      cfg.pattern_low    = pattern_low_ff;
      cfg.pattern_high   = pattern_high_ff;
      cfg.care_mask      = care_mask_ff;
      cfg.pattern_length = pattern_length_ff;
      cfg.result_offset  = result_offset_ff;
   end

endmodule

// ----- hdl/mbps_match.sv -----
// ----------------------------------------------------------------------------
// mbps_match
// Byte window, fill count and found flag, with the parallel masked compare.
// ----------------------------------------------------------------------------
module mbps_match #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mbps_pkg::item_type   item,
   input  mbps_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output mbps_pkg::result_type res
);
   import mbps_pkg::*;

   localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [7:0]        window_ff [MAX_PATTERN_BYTES];
   logic [7:0]        window_in [MAX_PATTERN_BYTES];
   logic [7:0]        window_base [MAX_PATTERN_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in, fill_base;
   logic              seen_ff, seen_in, seen_base;
   logic              clear_win;
   logic [LEN_W-1:0]  len_eff;
   logic              hit;
   logic [31:0]       start_addr;
   logic [31:0]       offset_ext;
   int                idx;

   // Clamp length to window depth
   always_comb begin
      if ({1'b0, cfg.pattern_length} > LEN_W'(MAX_PATTERN_BYTES)) begin
         len_eff = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = {1'b0, cfg.pattern_length};
      end
   end

   // Scan and region start clear the window before the byte goes in
   assign clear_win = item.scan_start | item.region_start;
   assign seen_base = seen_ff & ~item.scan_start;
   assign fill_base = clear_win ? '0 : fill_ff;

   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         window_base[j] = clear_win ? 8'h00 : window_ff[j];
      end
   end

   // Shift in the new byte unless the scan already matched
   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         window_in[j] = window_base[j];
      end
      fill_in = fill_base;
      if (!seen_base) begin
         for (int j = 0; j < MAX_PATTERN_BYTES - 1; j++) begin
            window_in[j] = window_base[j+1];
         end
         window_in[MAX_PATTERN_BYTES-1] = item.data_byte;
         if (fill_base < FILL_W'(MAX_PATTERN_BYTES)) begin
            fill_in = fill_base + 1'b1;
         end
      end
   end

   // Masked compare; pattern position i sits at window slot P - len + i
   always_comb begin
      hit = (LEN_W'(fill_in) >= len_eff);
      idx = 0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         idx = MAX_PATTERN_BYTES - int'(len_eff) + i;
         if ((LEN_W'(i) < len_eff) && (i < PATTERN_BYTES)) begin
            if (cfg.care_mask[i] &&
                (window_in[IDX_W'(idx)] !=
                 pattern_byte(cfg.pattern_low, cfg.pattern_high, i))) begin
               hit = 1'b0;
            end
         end
      end
   end

   // Match address: window start plus signed offset
   assign offset_ext = {{16{cfg.result_offset[15]}}, cfg.result_offset};

   always_comb begin
      if (len_eff != '0) begin
         start_addr = item.byte_address - 32'(len_eff) + 32'd1;
      end else begin
         start_addr = item.byte_address;
      end
   end

   always_comb begin
      res_valid         = 1'b0;
      res.found         = 1'b0;
      res.match_address = 32'h0;
      seen_in           = seen_base;
      if (!seen_base) begin
         if (hit) begin
            res_valid         = 1'b1;
            res.found         = 1'b1;
            res.match_address = start_addr + offset_ext;
            seen_in           = 1'b1;
         end else if (item.scan_end) begin
            res_valid = 1'b1;
         end
      end
   end

   // State update on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            window_ff[j] <= 8'h00;
         end
         fill_ff <= '0;
         seen_ff <= 1'b0;
      end else if (step) begin
         for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            window_ff[j] <= window_in[j];
         end
         fill_ff <= fill_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ----- hdl/masked_byte_pattern_scanner_top.sv -----
// Path: an accepted item goes to the input register, then any result it yields to the result register.
// Throughput: one byte per cycle unless stalled; the window compare is a single pass through mbps_match.
// A stalled result holds further progress once the input register is also full.
// Reset (synchronous): clears window, fill count, found flag, pipeline valids,
// and sets registers to defaults (pattern_length 1, others 0).
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Streaming masked byte signature search with APB-style configuration.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic [31:0]                     req_byte_address,
   input  logic                            req_region_start,
   input  logic                            req_scan_start,
   input  logic                            req_scan_end,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [31:0]                     rsp_match_address,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mbps_pkg::*;

   cfg_type    cfg;
   item_type   s1_item_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       out_free;
   logic       advance;
   logic       accept;
   logic       res_valid;
   result_type res;

   mbps_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake control
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign advance   = s1_valid_ff & out_free;
   assign req_stall = s1_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;

   assign s1_valid_in  = accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = out_free ? (advance & res_valid) : rsp_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.data_byte    <= req_data_byte;
         s1_item_ff.byte_address <= req_byte_address;
         s1_item_ff.region_start <= req_region_start;
         s1_item_ff.scan_start   <= req_scan_start;
         s1_item_ff.scan_end     <= req_scan_end;
      end
   end

   mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (s1_item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_match_address = rsp_ff.match_address;

endmodule
